[sv/gpf_pkg.sv]
// Package with shared constants and the result type of the Goldbach pair finder.
`timescale 1ns / 1ps

package gpf_pkg;

    // Default number of entries covered by the primality table.
    localparam int TABLE_SIZE_DEF = 65536;

    // Width of the query number and of the two primes of a result.
    localparam int NUM_W = 16;

    // One result item as it leaves the query engine.
    typedef struct packed {
        logic             found;
        logic [NUM_W-1:0] small_prime;
        logic [NUM_W-1:0] large_prime;
        logic             bad_request;
    } t_result;

endpackage

[sv/gpf_if.sv]
// Handshake interfaces for the query channel and the result channel.
`timescale 1ns / 1ps

interface gpf_query_if;
    logic                       valid;
    logic                       ready;
    logic [gpf_pkg::NUM_W-1:0]  even_number;

    modport source (output valid, output even_number, input ready);
    modport sink   (input valid, input even_number, output ready);
endinterface

interface gpf_result_if;
    logic                       valid;
    logic                       ready;
    logic                       found;
    logic [gpf_pkg::NUM_W-1:0]  small_prime;
    logic [gpf_pkg::NUM_W-1:0]  large_prime;
    logic                       bad_request;

    modport source (output valid, output found, output small_prime, output large_prime,
                    output bad_request, input ready);
    modport sink   (input valid, input found, input small_prime, input large_prime,
                    input bad_request, output ready);
endinterface

[sv/gpf_bit_ram.sv]
// Odd-number primality bit memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module gpf_bit_ram #(
    parameter int DEPTH = gpf_pkg::TABLE_SIZE_DEF / 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic          o_rdata_a,
    output logic          o_rdata_b
);

    logic r_mem [DEPTH];
    logic r_rdata_a;
    logic r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[sv/gpf_sieve.sv]
// Sieve engine: clears the odd-number table, then strikes out odd multiples of each prime.
`timescale 1ns / 1ps

module gpf_sieve #(
    parameter int TABLE_SIZE = gpf_pkg::TABLE_SIZE_DEF,
    parameter int OW         = $clog2(TABLE_SIZE / 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_we,
    output logic [OW-1:0] o_waddr,
    output logic          o_wdata,
    output logic [OW-1:0] o_raddr,
    input  logic          i_rdata,
    output logic          o_table_ready
);

    // Wide enough for TABLE_SIZE itself and for a multiple one step past it.
    localparam int            KW     = $clog2(TABLE_SIZE) + 1;
    localparam logic [KW-1:0] N_K    = KW'(TABLE_SIZE);
    localparam logic [OW-1:0] LAST_A = OW'(TABLE_SIZE / 2 - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_TEST,
        S_CHECK,
        S_MARK,
        S_DONE
    } t_state;

    t_state        r_state;
    logic [OW-1:0] r_addr;
    logic [KW-1:0] r_i;
    logic [KW-1:0] r_sq;
    logic [KW-1:0] r_step;
    logic [KW-1:0] r_k;

    // Memory requests follow the current state.
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_addr;
        o_wdata = 1'b0;
        o_raddr = OW'(r_i >> 1);
        unique case (r_state)
            S_CLEAR: begin
                // Every odd entry starts as prime, except the one for the number 1.
                o_we    = 1'b1;
                o_wdata = (r_addr != '0);
            end
            S_MARK: begin
                o_we    = (r_k < N_K);
                o_waddr = OW'(r_k >> 1);
            end
            S_TEST, S_CHECK, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign o_table_ready = (r_state == S_DONE);

    // Sieve sequencer. The square of the candidate is kept up to date by adding 4i + 4.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_i    <= KW'(3);
                    r_sq   <= KW'(9);
                    r_step <= KW'(6);
                    if (r_addr == LAST_A) begin
                        r_state <= S_TEST;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_TEST: begin
                    if (r_sq < N_K) begin
                        r_state <= S_CHECK;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CHECK: begin
                    if (i_rdata) begin
                        r_k     <= r_sq;
                        r_state <= S_MARK;
                    end else begin
                        r_i     <= r_i + KW'(2);
                        r_sq    <= r_sq + (r_step << 1) + KW'(4);
                        r_step  <= r_step + KW'(4);
                        r_state <= S_TEST;
                    end
                end
                S_MARK: begin
                    if (r_k < N_K) begin
                        r_k <= r_k + r_step;
                    end else begin
                        r_i     <= r_i + KW'(2);
                        r_sq    <= r_sq + (r_step << 1) + KW'(4);
                        r_step  <= r_step + KW'(4);
                        r_state <= S_TEST;
                    end
                end
                S_DONE: begin
                end
                default: begin
                    r_state <= S_DONE;
                end
            endcase
        end
    end

endmodule

[sv/gpf_query.sv]
// Query engine: scans odd candidates against the bit table and registers one result.
`timescale 1ns / 1ps

module gpf_query #(
    parameter int TABLE_SIZE = gpf_pkg::TABLE_SIZE_DEF,
    parameter int OW         = $clog2(TABLE_SIZE / 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_table_ready,
    gpf_query_if.sink     i_query,
    gpf_result_if.source  o_result,
    output logic [OW-1:0] o_raddr_a,
    output logic [OW-1:0] o_raddr_b,
    input  logic          i_rdata_a,
    input  logic          i_rdata_b
);

    localparam int NW = gpf_pkg::NUM_W;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_SCAN,
        Q_PUSH
    } t_state;

    t_state           r_state;
    logic [NW-1:0]    r_n;
    logic [NW-1:0]    r_half;
    logic [NW-1:0]    r_p;
    logic [NW-1:0]    r_pd;
    logic             r_pend;
    gpf_pkg::t_result r_res;
    gpf_pkg::t_result r_out;
    logic             r_out_valid;

    logic          w_bad;
    logic [NW-1:0] w_diff;
    logic          w_slot_free;
    logic          w_load;

    assign w_bad       = i_query.even_number[0] ||
                         (32'(i_query.even_number) >= 32'(TABLE_SIZE));
    assign w_diff      = r_n - r_p;
    assign w_slot_free = !r_out_valid || o_result.ready;
    assign w_load      = (r_state == Q_PUSH) && w_slot_free;

    // Both bits of a candidate pair are read in the same cycle.
    assign o_raddr_a = OW'(r_p >> 1);
    assign o_raddr_b = OW'(w_diff >> 1);

    assign i_query.ready        = (r_state == Q_IDLE) && i_table_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.found       = r_out.found;
    assign o_result.small_prime = r_out.small_prime;
    assign o_result.large_prime = r_out.large_prime;
    assign o_result.bad_request = r_out.bad_request;

    // Scan sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= Q_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The output register loads a finished result or empties on a transfer.
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                Q_IDLE: begin
                    if (i_query.valid && i_table_ready) begin
                        r_n    <= i_query.even_number;
                        r_half <= {1'b0, i_query.even_number[NW-1:1]} + NW'(1);
                        r_p    <= NW'(3);
                        r_pend <= 1'b0;
                        r_res  <= {1'b0, {NW{1'b0}}, {NW{1'b0}}, w_bad};
                        if (w_bad) begin
                            r_state <= Q_PUSH;
                        end else begin
                            r_state <= Q_SCAN;
                        end
                    end
                end
                Q_SCAN: begin
                    // The candidate read last cycle is judged before a new one goes out.
                    priority if (r_pend && i_rdata_a && i_rdata_b) begin
                        r_res.found       <= 1'b1;
                        r_res.small_prime <= r_pd;
                        r_res.large_prime <= r_n - r_pd;
                        r_pend            <= 1'b0;
                        r_state           <= Q_PUSH;
                    end else if (r_p <= r_half) begin
                        r_pd   <= r_p;
                        r_pend <= 1'b1;
                        r_p    <= r_p + NW'(2);
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= Q_PUSH;
                    end
                end
                Q_PUSH: begin
                    if (w_slot_free) begin
                        r_out   <= r_res;
                        r_state <= Q_IDLE;
                    end
                end
                default: begin
                    r_state <= Q_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/goldbach_pair_finder_top.sv]
// Top level of the Goldbach pair finder: sieve, query engine and primality bit memory.
`timescale 1ns / 1ps

// Usage:
// i_query carries one even number per transfer, o_result returns one item per query
// with found, small_prime, large_prime and bad_request. An odd number, or one that is
// not below TABLE_SIZE, comes back with bad_request set and all other fields zero.
// After reset the sieve first runs a clearing pass over TABLE_SIZE/2 odd entries, one
// per cycle, and then strikes out odd multiples of each prime below the square root of
// TABLE_SIZE, one entry per cycle. i_query.ready stays low until the table is complete.
// For a query, the scan issues one candidate pair per cycle on the two read ports of
// the bit memory until a pair of primes is found or the candidates are used up; a bad
// request skips the scan. One query is in work at a time; the next is taken once the
// previous result sits in the output register, so a stalled receiver holds at most one
// waiting result and one finished scan before the query channel stops.

module goldbach_pair_finder_top #(
    parameter int TABLE_SIZE = gpf_pkg::TABLE_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gpf_query_if.sink    i_query,
    gpf_result_if.source o_result
);

    localparam int DEPTH = TABLE_SIZE / 2;
    localparam int OW    = $clog2(DEPTH);

    logic          w_table_ready;
    logic          w_we;
    logic [OW-1:0] w_waddr;
    logic          w_wdata;
    logic [OW-1:0] w_sieve_raddr;
    logic [OW-1:0] w_query_raddr_a;
    logic [OW-1:0] w_query_raddr_b;
    logic [OW-1:0] w_raddr_a;
    logic          w_rdata_a;
    logic          w_rdata_b;

    // The sieve owns read port A until the table is complete.
    assign w_raddr_a = w_table_ready ? w_query_raddr_a : w_sieve_raddr;

    gpf_bit_ram #(
        .DEPTH (DEPTH),
        .AW    (OW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_query_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    gpf_sieve #(
        .TABLE_SIZE (TABLE_SIZE),
        .OW         (OW)
    ) u_sieve (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_we          (w_we),
        .o_waddr       (w_waddr),
        .o_wdata       (w_wdata),
        .o_raddr       (w_sieve_raddr),
        .i_rdata       (w_rdata_a),
        .o_table_ready (w_table_ready)
    );

    gpf_query #(
        .TABLE_SIZE (TABLE_SIZE),
        .OW         (OW)
    ) u_query (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_table_ready (w_table_ready),
        .i_query       (i_query),
        .o_result      (o_result),
        .o_raddr_a     (w_query_raddr_a),
        .o_raddr_b     (w_query_raddr_b),
        .i_rdata_a     (w_rdata_a),
        .i_rdata_b     (w_rdata_b)
    );

endmodule
